>>> rtl/tpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types, register indexes and pixel widening for the targa pixel run
// decoder.
// ----------------------------------------------------------------------------
package tpr_pkg;

  // pixel formats as coded in the format register
  typedef enum logic [1:0] {
    FMT_ARGB1555 = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_BGR      = 2'd2,
    FMT_BGRA     = 2'd3
  } pix_fmt_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_RLE_ENABLED  = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  typedef struct packed {
    pix_fmt_e    fmt;
    logic        rle;
    logic [15:0] width;
    logic [15:0] height;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pixel_argb;
    logic [7:0]  repeat_count;
    logic        end_of_image;
    logic        run_clipped;
  } result_t;

  // index of the last byte of a pixel in the given format
  function automatic logic [1:0] last_byte_idx(pix_fmt_e fmt);
    logic [1:0] idx;
    unique case (fmt)
      FMT_ARGB1555: idx = 2'd1;
      FMT_RGB565:   idx = 2'd1;
      FMT_BGR:      idx = 2'd2;
      FMT_BGRA:     idx = 2'd3;
      default:      idx = 2'd2;
    endcase
    return idx;
  endfunction

  // widen a little-endian assembled pixel word to 32-bit argb
  function automatic logic [31:0] widen_pixel(logic [31:0] word, pix_fmt_e fmt);
    logic [31:0] argb;
    unique case (fmt)
      FMT_ARGB1555: argb = {{8{word[15]}}, word[14:10], 3'b000,
                            word[9:5], 3'b000, word[4:0], 3'b000};
      FMT_RGB565:   argb = {AlphaOpaque, word[15:11], 3'b000,
                            word[10:5], 2'b00, word[4:0], 3'b000};
      FMT_BGR:      argb = {AlphaOpaque, word[23:0]};
      FMT_BGRA:     argb = word;
      default:      argb = word;
    endcase
    return argb;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tpr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_cfg_regs
// Configuration registers and the registered image pixel total.
// ----------------------------------------------------------------------------
module tpr_cfg_regs
  import tpr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o,
  output logic [31:0]              total_o
);

  cfg_t        cfg_q, cfg_d;
  logic [31:0] total_q, total_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PIXEL_FORMAT: cfg_d.fmt    = pix_fmt_e'(cfg_data_i[1:0]);
        CFG_RLE_ENABLED:  cfg_d.rle    = cfg_data_i[0];
        CFG_IMAGE_WIDTH:  cfg_d.width  = cfg_data_i[15:0];
        CFG_IMAGE_HEIGHT: cfg_d.height = cfg_data_i[15:0];
        default:          cfg_d        = cfg_q;
      endcase
    end
  end

  // pixel total, a zero dimension counts as a one-pixel image
  always_comb begin
    if (cfg_q.width == 16'd0 || cfg_q.height == 16'd0) begin
      total_d = 32'd1;
    end else begin
      total_d = cfg_q.width * cfg_q.height;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= FMT_BGR;
      cfg_q.rle    <= 1'b0;
      cfg_q.width  <= 16'd1;
      cfg_q.height <= 16'd1;
      total_q      <= 32'd1;
    end else begin
      cfg_q   <= cfg_d;
      total_q <= total_d;
    end
  end

  assign cfg_o   = cfg_q;
  assign total_o = total_q;

endmodule
`default_nettype wire

>>> rtl/tpr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_core
// Packet and pixel assembly state; decodes one byte per cycle, when fire_i
// is high, into at most one pixel result.
// ----------------------------------------------------------------------------
module tpr_core
  import tpr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire cfg_t        cfg_i,
  input  wire logic [31:0] total_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  logic        exp_hdr_q, exp_hdr_d;
  logic        is_run_q, is_run_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  idx_q, idx_d;
  logic [23:0] held_q, held_d;
  logic [31:0] done_q, done_d;

  logic        is_hdr;
  logic        partial;
  logic [31:0] lane_word;
  logic [31:0] word;
  logic [7:0]  count;
  logic [32:0] diff;
  logic [31:0] remaining;
  logic        rem_wide;
  logic        clip;
  logic        end_img;
  logic [7:0]  count_out;

  assign is_hdr    = cfg_i.rle && exp_hdr_q;
  assign partial   = idx_q < last_byte_idx(cfg_i.fmt);
  assign lane_word = {24'd0, data_byte_i} << {idx_q, 3'b000};
  assign word      = {8'd0, held_q} | lane_word;

  // repeat count before clipping
  always_comb begin
    count = 8'd1;
    if (cfg_i.rle && is_run_q && left_q != 8'd0) begin
      count = left_q;
    end
  end

  // pixels left in the image, at least one
  assign diff = {1'b0, total_i} - {1'b0, done_q};
  always_comb begin
    if (diff[32] || diff[31:0] == 32'd0) begin
      remaining = 32'd1;
    end else begin
      remaining = diff[31:0];
    end
  end

  assign rem_wide  = |remaining[31:8];
  assign clip      = !rem_wide && (count > remaining[7:0]);
  assign count_out = clip ? remaining[7:0] : count;
  assign end_img   = !rem_wide && (count_out >= remaining[7:0]);

  // next stream state
  always_comb begin
    exp_hdr_d = exp_hdr_q;
    is_run_d  = is_run_q;
    left_d    = left_q;
    idx_d     = idx_q;
    held_d    = held_q;
    done_d    = done_q;
    if (fire_i) begin
      if (is_hdr) begin
        is_run_d  = data_byte_i[7];
        left_d    = {1'b0, data_byte_i[6:0]} + 8'd1;
        exp_hdr_d = 1'b0;
        idx_d     = 2'd0;
        held_d    = 24'd0;
      end else if (partial) begin
        held_d = held_q | lane_word[23:0];
        idx_d  = idx_q + 2'd1;
      end else begin
        idx_d  = 2'd0;
        held_d = 24'd0;
        if (cfg_i.rle) begin
          if (is_run_q) begin
            left_d    = 8'd0;
            exp_hdr_d = 1'b1;
          end else begin
            if (left_q != 8'd0) begin
              left_d = left_q - 8'd1;
            end
            if (left_q <= 8'd1) begin
              exp_hdr_d = 1'b1;
            end
          end
        end
        done_d = done_q + {24'd0, count};
        // image complete: back to the start of a stream
        if (end_img) begin
          exp_hdr_d = 1'b1;
          is_run_d  = 1'b0;
          left_d    = 8'd0;
          done_d    = 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_hdr_q <= 1'b1;
      is_run_q  <= 1'b0;
      left_q    <= 8'd0;
      idx_q     <= 2'd0;
      held_q    <= 24'd0;
      done_q    <= 32'd0;
    end else begin
      exp_hdr_q <= exp_hdr_d;
      is_run_q  <= is_run_d;
      left_q    <= left_d;
      idx_q     <= idx_d;
      held_q    <= held_d;
      done_q    <= done_d;
    end
  end

  assign res_valid_o        = !is_hdr && !partial;
  assign res_o.pixel_argb   = widen_pixel(word, cfg_i.fmt);
  assign res_o.repeat_count = count_out;
  assign res_o.end_of_image = end_img;
  assign res_o.run_clipped  = clip;

endmodule
`default_nettype wire

>>> rtl/tga_pixel_run_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_pixel_run_decoder_unit
// Targa pixel data decoder: bytes in, argb pixels with repeat counts out.
// ----------------------------------------------------------------------------
// Takes one pixel-data byte per cycle while the result register is not
// stalled, and gives one result per completed pixel (header bytes and
// partial pixel bytes give none). A byte passes an input register and the
// decode logic into the result register. The result register frees in the
// cycle it transfers, so a new byte is taken while a finished pixel still
// waits. A write to the width or height registers reaches the pixel total
// through the configuration register and a registered 16x16 product. Pixel
// bytes arrive least significant first.
module tga_pixel_run_decoder_unit
  import tpr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          data_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [31:0]              pixel_argb_o,
  output logic [7:0]               repeat_count_o,
  output logic                     end_of_image_o,
  output logic                     run_clipped_o
);

  cfg_t        cfg;
  logic [31:0] total;
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        slot_free;
  logic        fire;
  logic        res_valid;
  result_t     res;
  logic        out_valid_q;
  result_t     out_q;

  tpr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .total_o     (total)
  );

  // result slot is free when empty or when it transfers this cycle
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && slot_free;
  assign in_stall_o = in_valid_q && !slot_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
    end
  end

  tpr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (byte_q),
    .cfg_i       (cfg),
    .total_i     (total),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_argb_o   = out_q.pixel_argb;
  assign repeat_count_o = out_q.repeat_count;
  assign end_of_image_o = out_q.end_of_image;
  assign run_clipped_o  = out_q.run_clipped;

endmodule
`default_nettype wire

>>> rtl/tpr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_checker
// Port-level checks for the targa pixel run decoder, bound to the top level.
// ----------------------------------------------------------------------------
module tpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  repeat_count_o,
  input wire logic        end_of_image_o,
  input wire logic        run_clipped_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // repeat count stays within one packet
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (repeat_count_o != 8'd0) && (repeat_count_o <= 8'd128))
    else $error("repeat count out of range");

  // a clipped run always closes the image
  a_clip_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_clipped_o |-> end_of_image_o)
    else $error("clipped run without end of image");

  // with the result slot empty the input never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result slot");

endmodule

bind tga_pixel_run_decoder_unit tpr_checker u_tpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .repeat_count_o (repeat_count_o),
  .end_of_image_o (end_of_image_o),
  .run_clipped_o  (run_clipped_o)
);
`default_nettype wire

>>> bench/tb_tga_pixel_run_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tga_pixel_run_decoder_unit
// Self-checking bench for the targa pixel run decoder.
// ----------------------------------------------------------------------------
// A directed pass walks every pixel format, run and literal packets, clipped
// runs, literal packets that overrun the image, a zero image size and an
// image size shrunk mid-stream. A random pass then streams whole images with
// random content under random configurations, with some streams cut short
// and reconfigured mid-image. A predictor class tracks the decoder state for
// every byte transfer and queues the expected pixels. Each pixel transfer is
// checked against the oldest queued pixel, field by field. Both handshakes
// idle at random.
// ----------------------------------------------------------------------------
module tb_tga_pixel_run_decoder_unit;
  import tpr_pkg::*;

  localparam int unsigned RandomBytes  = 900;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 4;

  // tracks decoder state and holds the pixels still owed by the block
  class tga_pixel_predictor;
    pix_fmt_e    fmt;
    bit          rle_on;
    logic [15:0] width;
    logic [15:0] height;
    bit          want_header;
    bit          run_pkt;
    logic [7:0]  pkt_left;
    logic [1:0]  byte_idx;
    logic [23:0] held;
    logic [31:0] done_px;
    result_t     pending_pixels[$];
    int unsigned images;
    int unsigned fails;

    function new();
      fmt    = FMT_BGR;
      rle_on = 1'b0;
      width  = 16'd1;
      height = 16'd1;
      images = 0;
      fails  = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      want_header = 1'b1;
      run_pkt     = 1'b0;
      pkt_left    = 8'd0;
      byte_idx    = 2'd0;
      held        = 24'd0;
      done_px     = 32'd0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_PIXEL_FORMAT: fmt = pix_fmt_e'(val[1:0]);
        CFG_RLE_ENABLED:  rle_on = val[0];
        CFG_IMAGE_WIDTH:  width = val[15:0];
        CFG_IMAGE_HEIGHT: height = val[15:0];
        default: ;
      endcase
    endfunction

    // one accepted byte: header, partial pixel, or completed pixel
    function void note_byte(logic [7:0] b);
      int          nbytes;
      logic [31:0] word;
      logic [32:0] total;
      logic [32:0] remaining;
      logic [32:0] count;
      logic        clipped;
      logic        last;
      logic [7:0]  a;
      logic [7:0]  rd;
      logic [7:0]  gr;
      logic [7:0]  bl;
      result_t     px;

      // packet header opens a run or a literal packet
      if (rle_on && want_header) begin
        run_pkt     = b[7];
        pkt_left    = {1'b0, b[6:0]} + 8'd1;
        want_header = 1'b0;
        byte_idx    = 2'd0;
        held        = 24'd0;
        return;
      end

      case (fmt)
        FMT_BGR:  nbytes = 3;
        FMT_BGRA: nbytes = 4;
        default:  nbytes = 2;
      endcase

      // gather low bytes of the pixel
      if (int'(byte_idx) + 1 < nbytes) begin
        held     = held | 24'(32'(b) << (8 * byte_idx));
        byte_idx = byte_idx + 2'd1;
        return;
      end

      word     = {8'h00, held} | (32'(b) << (8 * byte_idx));
      byte_idx = 2'd0;
      held     = 24'd0;

      // repeat count from the packet
      count = 33'd1;
      if (rle_on) begin
        if (run_pkt) begin
          count       = (pkt_left != 8'd0) ? 33'(pkt_left) : 33'd1;
          pkt_left    = 8'd0;
          want_header = 1'b1;
        end else begin
          if (pkt_left != 8'd0) pkt_left = pkt_left - 8'd1;
          if (pkt_left == 8'd0) want_header = 1'b1;
        end
      end

      // clip against the pixels left in the image
      total = 33'(width) * 33'(height);
      if (total == 33'd0) total = 33'd1;
      remaining = (33'(done_px) < total) ? total - 33'(done_px) : 33'd1;
      clipped   = 1'b0;
      if (count > remaining) begin
        count   = remaining;
        clipped = 1'b1;
      end
      last    = (count >= remaining);
      done_px = done_px + count[31:0];

      // channel widening per format
      case (fmt)
        FMT_ARGB1555: begin
          a  = word[15] ? 8'hFF : 8'h00;
          rd = {word[14:10], 3'b000};
          gr = {word[9:5], 3'b000};
          bl = {word[4:0], 3'b000};
        end
        FMT_RGB565: begin
          a  = 8'hFF;
          rd = {word[15:11], 3'b000};
          gr = {word[10:5], 2'b00};
          bl = {word[4:0], 3'b000};
        end
        FMT_BGR: begin
          a  = 8'hFF;
          rd = word[23:16];
          gr = word[15:8];
          bl = word[7:0];
        end
        default: begin
          a  = word[31:24];
          rd = word[23:16];
          gr = word[15:8];
          bl = word[7:0];
        end
      endcase

      px.pixel_argb   = {a, rd, gr, bl};
      px.repeat_count = count[7:0];
      px.end_of_image = last;
      px.run_clipped  = clipped;
      pending_pixels.push_back(px);
      if (last) begin
        images++;
        clear_stream();
      end
    endfunction

    function void check_pixel(result_t got);
      result_t want;
      if (pending_pixels.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected pixel: argb %08h count %0d end %0b clip %0b",
                   got.pixel_argb, got.repeat_count, got.end_of_image, got.run_clipped);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_argb !== want.pixel_argb || got.repeat_count !== want.repeat_count ||
          got.end_of_image !== want.end_of_image || got.run_clipped !== want.run_clipped) begin
        fails++;
        if (fails <= 10)
          $display("pixel mismatch: exp argb %08h count %0d end %0b clip %0b / %s",
                   want.pixel_argb, want.repeat_count, want.end_of_image, want.run_clipped,
                   $sformatf("got argb %08h count %0d end %0b clip %0b", got.pixel_argb,
                             got.repeat_count, got.end_of_image, got.run_clipped));
      end
    endfunction

    // next stream byte: a header where one is due, else pixel data
    function logic [7:0] make_byte();
      if (rle_on && want_header) begin
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return {1'($urandom), 7'($urandom_range(0, 7))};
      end
      return 8'($urandom);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          data_byte;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [31:0]         pixel_argb;
  logic [7:0]          repeat_count;
  logic                end_of_image;
  logic                run_clipped;

  tga_pixel_predictor predictor;
  bit                 calm = 1'b0;
  int unsigned        cycles = 0;
  int unsigned        stall_hold = 0;
  int unsigned        bytes_sent = 0;

  tga_pixel_run_decoder_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_argb_o   (pixel_argb),
    .repeat_count_o (repeat_count),
    .end_of_image_o (end_of_image),
    .run_clipped_o  (run_clipped)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // image dimension: mostly small, sometimes zero, full or random
  function automatic logic [15:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom);
    return 16'($urandom_range(1, 8));
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst_n !== 1'b1 || calm) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      out_stall  <= ($urandom_range(0, 1) == 0);
      stall_hold = pick_gap();
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    result_t seen;
    if (rst_n === 1'b1) begin
      if (out_valid && !out_stall) begin
        seen.pixel_argb   = pixel_argb;
        seen.repeat_count = repeat_count;
        seen.end_of_image = end_of_image;
        seen.run_clipped  = run_clipped;
        predictor.check_pixel(seen);
      end
      if (in_valid && !in_stall) predictor.note_byte(data_byte);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input int unsigned gap, input logic [7:0] value);
    bit taken;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= value;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  // hold off input until every owed pixel has arrived
  task automatic drain();
    in_valid <= 1'b0;
    while (predictor.pending_pixels.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    predictor.set_reg(idx, val);
    // the pixel total is registered behind the size registers
    repeat (2) @(negedge clk);
  endtask

  initial begin
    int unsigned start_bytes;
    int unsigned start_images;
    int unsigned budget;
    int unsigned n;
    bit          first;

    predictor = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_PIXEL_FORMAT;
    cfg_data  = '0;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: one bgr pixel fills a 1x1 image
    send_byte(0, 8'h00);
    send_byte(0, 8'h80);
    send_byte(0, 8'hFF);

    // argb1555 raw, alpha set then clear
    write_reg(CFG_PIXEL_FORMAT, FMT_ARGB1555);
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    send_byte(0, 8'hFF);
    send_byte(0, 8'hFF);
    send_byte(1, 8'h00);
    send_byte(0, 8'h7C);

    // rgb565 rle: a run, then a literal packet that overruns the image
    write_reg(CFG_PIXEL_FORMAT, FMT_RGB565);
    write_reg(CFG_RLE_ENABLED, 16'd1);
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    send_byte(0, 8'h81);
    send_byte(0, 8'hFF);
    send_byte(0, 8'hFF);
    send_byte(2, 8'h02);
    send_byte(0, 8'h1F);
    send_byte(0, 8'hF8);

    // bgra: longest run clipped at the image end
    write_reg(CFG_PIXEL_FORMAT, FMT_BGRA);
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    send_byte(0, 8'hFF);
    send_byte(0, 8'h10);
    send_byte(0, 8'h20);
    send_byte(0, 8'h30);
    send_byte(0, 8'h40);

    // zero width counts as a one pixel image
    write_reg(CFG_RLE_ENABLED, 16'd0);
    write_reg(CFG_PIXEL_FORMAT, FMT_RGB565);
    write_reg(CFG_IMAGE_WIDTH, 16'd0);
    send_byte(0, 8'h00);
    send_byte(0, 8'h00);

    // shrink the image below the pixels already done
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    send_byte(0, 8'hE0);
    send_byte(0, 8'h07);
    send_byte(0, 8'h5A);
    send_byte(0, 8'hA5);
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    send_byte(0, 8'h33);
    send_byte(0, 8'hCC);

    // random images under random configurations
    start_bytes = bytes_sent;
    first       = 1'b1;
    while (bytes_sent - start_bytes < RandomBytes) begin
      calm = ($urandom_range(0, 5) == 0);
      if (first || $urandom_range(0, 9) < 7)
        write_reg(CFG_PIXEL_FORMAT, 16'($urandom));
      if (first || $urandom_range(0, 9) < 7)
        write_reg(CFG_RLE_ENABLED, {15'($urandom), 1'($urandom_range(0, 3) != 0)});
      if (first || $urandom_range(0, 9) < 7)
        write_reg(CFG_IMAGE_WIDTH, pick_dim());
      if (first || $urandom_range(0, 9) < 7)
        write_reg(CFG_IMAGE_HEIGHT, pick_dim());
      first = 1'b0;

      // one image, or a stream cut short for a mid-image reconfiguration
      start_images = predictor.images;
      budget       = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 20) : 300;
      n            = 0;
      while (n < budget && predictor.images == start_images &&
             bytes_sent - start_bytes < RandomBytes) begin
        if (!calm && $urandom_range(0, 49) == 0) drain();
        send_byte(calm ? 0 : pick_gap(), predictor.make_byte());
        n++;
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (predictor.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
